// ===== design/descending_sorted_insert_list_macros.svh =====
// Assertion macros for the descending sorted insert list.
// Used by the top level only; needs a signal named clock and one named reset.
`ifndef DESCENDING_SORTED_INSERT_LIST_MACROS_SVH
`define DESCENDING_SORTED_INSERT_LIST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DSIL_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DSIL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dsil_pkg.sv =====
// Shared constants and types for the descending sorted insert list.
// No dependencies; used by dsil_cell and descending_sorted_insert_list.
`timescale 1ns / 1ps

package dsil_pkg;

   localparam int DSIL_CAPACITY = 64;
   localparam int DATA_W        = 32;
   localparam int INDEX_W       = 6;
   localparam int COUNT_OUT_W   = 7;
   localparam int LANE_W        = 3;
   localparam int LANES         = 1 << LANE_W;
   localparam int READ_SLOTS    = 1 << INDEX_W;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_READ   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   // Insert broadcast to every cell of the chain.
   typedef struct packed {
      logic                     shift_en;
      logic signed [DATA_W-1:0] value;
   } dsil_ins_type;

endpackage

// ===== design/descending_sorted_insert_list.sv =====
// Top level of the descending sorted insert list: cell chain, read tree, result buffering.
// Depends on dsil_pkg, dsil_cell and descending_sorted_insert_list_macros.svh.
//
// Usage:
//   req_ channel carries one operation (func, value, index); rsp_ channel returns
//   exactly one result (ok, data, count, full_res) per operation, in order.
//   Insert places the value ahead of the first smaller entry in a row of cells
//   that all compare and shift in the same cycle; read picks the entry through a
//   two-level lane tree; clear zeroes the count.
//   Path: each result passes through the pending stage and then the output register.
//   Throughput: one operation per cycle while req_ready stays high (see Stall), set
//   by the cell update and the one-stage read tree register.
//   Stall: a pending stage and the output register hold up to two results;
//   req_ready drops while both are occupied and rsp_ready is low.
//   Reset: count goes to zero, both result stages empty; cell contents are not
//   cleared and are only read below the count.
`timescale 1ns / 1ps

`include "descending_sorted_insert_list_macros.svh"

module descending_sorted_insert_list #(
   parameter int CAPACITY = dsil_pkg::DSIL_CAPACITY
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_func,
   input  logic signed [dsil_pkg::DATA_W-1:0]    req_value,
   input  logic [dsil_pkg::INDEX_W-1:0]          req_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_ok,
   output logic signed [dsil_pkg::DATA_W-1:0]    rsp_data,
   output logic [dsil_pkg::COUNT_OUT_W-1:0]      rsp_count,
   output logic                                  rsp_full_res
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int DW    = dsil_pkg::DATA_W;
   localparam int LANES = dsil_pkg::LANES;
   localparam int LW    = dsil_pkg::LANE_W;
   localparam int IW    = dsil_pkg::INDEX_W;
   localparam int OW    = dsil_pkg::COUNT_OUT_W;

   logic [CNT_W-1:0]      count_ff, count_in;
   dsil_pkg::dsil_ins_type ins;
   logic signed [DW-1:0]  cell_entry [CAPACITY];
   logic                  cell_lt    [CAPACITY];
   logic signed [DW-1:0]  slot       [dsil_pkg::READ_SLOTS];
   logic                  accept, full, is_insert, is_read, is_clear, out_free;

   // pending stage
   logic                  pend_v_ff, pend_v_in;
   logic                  pend_ok_ff, pend_rd_ff, pend_full_ff;
   logic [CNT_W-1:0]      pend_count_ff;
   logic [IW-LW-1:0]      pend_hi_ff;
   logic signed [DW-1:0]  grp_ff [LANES];
   logic signed [DW-1:0]  grp_in [LANES];
   logic                  ok_in;

   // output stage
   logic                  out_v_ff, out_v_in;
   logic                  out_ok_ff, out_full_ff;
   logic signed [DW-1:0]  out_data_ff;
   logic [CNT_W-1:0]      out_count_ff;
   logic [CNT_W+OW-1:0]   count_ext;

   assign out_free  = !out_v_ff || rsp_ready;
   assign req_ready = !pend_v_ff || out_free;
   assign accept    = req_valid && req_ready;
   assign full      = count_ff == CNT_W'(CAPACITY);
   assign is_insert = req_func == dsil_pkg::FUNC_INSERT;
   assign is_read   = req_func == dsil_pkg::FUNC_READ;
   assign is_clear  = req_func == dsil_pkg::FUNC_CLEAR;

   assign ins.shift_en = accept && is_insert && !full;
   assign ins.value    = req_value;

   genvar k;
   generate
      for (k = 0; k < CAPACITY; k++) begin : g_cell
         if (k == 0) begin : g_head
            dsil_cell #(.INDEX(k), .CNT_W(CNT_W)) u_cell (
               .clock      (clock),
               .ins        (ins),
               .count      (count_ff),
               .left_entry (req_value),
               .left_lt    (1'b0),
               .entry      (cell_entry[k]),
               .lt         (cell_lt[k])
            );
         end else begin : g_body
            dsil_cell #(.INDEX(k), .CNT_W(CNT_W)) u_cell (
               .clock      (clock),
               .ins        (ins),
               .count      (count_ff),
               .left_entry (cell_entry[k-1]),
               .left_lt    (cell_lt[k-1]),
               .entry      (cell_entry[k]),
               .lt         (cell_lt[k])
            );
         end
      end
      for (k = 0; k < dsil_pkg::READ_SLOTS; k++) begin : g_slot
         if (k < CAPACITY) begin : g_used
            assign slot[k] = cell_entry[k];
         end else begin : g_pad
            assign slot[k] = '0;
         end
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (accept && is_clear) begin
         count_in = '0;
      end else if (ins.shift_en) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      for (int g = 0; g < LANES; g++) begin
         grp_in[g] = slot[{LW'(g), req_index[LW-1:0]}];
      end
   end

   always_comb begin
      ok_in = 1'b0;
      if (is_insert) begin
         ok_in = !full;
      end else if (is_read) begin
         ok_in = {{CNT_W{1'b0}}, req_index} < {{IW{1'b0}}, count_ff};
      end else if (is_clear) begin
         ok_in = 1'b1;
      end
   end

   always_comb begin
      pend_v_in = pend_v_ff;
      if (accept) begin
         pend_v_in = 1'b1;
      end else if (out_free) begin
         pend_v_in = 1'b0;
      end
      out_v_in = out_v_ff;
      if (pend_v_ff && out_free) begin
         out_v_in = 1'b1;
      end else if (rsp_ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         count_ff  <= count_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ok_ff    <= ok_in;
         pend_rd_ff    <= is_read && ok_in;
         pend_count_ff <= count_in;
         pend_full_ff  <= count_in == CNT_W'(CAPACITY);
         pend_hi_ff    <= req_index[IW-1:LW];
         for (int g = 0; g < LANES; g++) begin
            grp_ff[g] <= grp_in[g];
         end
      end
      if (pend_v_ff && out_free) begin
         out_ok_ff    <= pend_ok_ff;
         out_data_ff  <= pend_rd_ff ? grp_ff[pend_hi_ff] : '0;
         out_count_ff <= pend_count_ff;
         out_full_ff  <= pend_full_ff;
      end
   end

   assign count_ext    = {{OW{1'b0}}, out_count_ff};
   assign rsp_valid    = out_v_ff;
   assign rsp_ok       = out_ok_ff;
   assign rsp_data     = out_data_ff;
   assign rsp_count    = count_ext[OW-1:0];
   assign rsp_full_res = out_full_ff;

   `DSIL_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `DSIL_ASSERT_NEXT(a_insert_count, ins.shift_en, count_ff == $past(count_ff) + CNT_W'(1), "insert did not advance count")
   `DSIL_ASSERT_NEXT(a_pend_hold, pend_v_ff && !out_free, pend_v_ff, "pending result dropped while stalled")
   `DSIL_ASSERT_SAME(a_sorted_head, count_ff >= CNT_W'(2), cell_entry[0] >= cell_entry[1], "head cells out of order")

endmodule

// ===== design/dsil_cell.sv =====
// One storage cell of the sorted chain: holds an entry, shifted from the left or inserted.
// Depends on dsil_pkg.
`timescale 1ns / 1ps

module dsil_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic                             clock,
   input  dsil_pkg::dsil_ins_type           ins,
   input  logic [CNT_W-1:0]                 count,
   input  logic signed [dsil_pkg::DATA_W-1:0] left_entry,
   input  logic                             left_lt,
   output logic signed [dsil_pkg::DATA_W-1:0] entry,
   output logic                             lt
);

   logic signed [dsil_pkg::DATA_W-1:0] entry_ff;
   logic signed [dsil_pkg::DATA_W-1:0] entry_in;
   logic                               valid;

   assign valid = CNT_W'(INDEX) < count;
   assign lt    = !valid || (entry_ff < ins.value);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ins.shift_en && lt) begin
         entry_in = left_lt ? left_entry : ins.value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
